// ===== hdl/lr_pkg.sv =====
// Package: line rasterizer widths, sequencer codes and microcode table.
`timescale 1ns / 1ps
`default_nettype none
package lr_pkg;

    // Port field width and working coordinate width.
    localparam int FIELD_W    = 6;
    localparam int COORD_BITS = 6;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int STEP_BITS  = 2;

    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [STEP_BITS-1:0]  t_step;

    // Stall condition of a microcode step.
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_IN   = 2'd1;
    localparam logic [1:0] HOLD_OUT  = 2'd2;

    // Jump condition of a microcode step.
    localparam logic [1:0] COND_NEXT   = 2'd0;
    localparam logic [1:0] COND_ALWAYS = 2'd1;
    localparam logic [1:0] COND_MORE   = 2'd2;

    // Step addresses.
    localparam t_step ST_FETCH = 2'd0;
    localparam t_step ST_AXES  = 2'd1;
    localparam t_step ST_ERR   = 2'd2;
    localparam t_step ST_EMIT  = 2'd3;

    typedef struct packed {
        logic [1:0] hold_on;
        logic       load_pts;
        logic       load_axes;
        logic       init_err;
        logic       emit;
        logic [1:0] cond;
        t_step      target;
    } t_uword;

    // Emit step loops on itself until the last pixel, then the step
    // counter wraps back to the fetch step.
    localparam t_uword UCODE [4] = '{
        '{HOLD_IN,   1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, ST_FETCH},
        '{HOLD_NONE, 1'b0, 1'b1, 1'b0, 1'b0, COND_NEXT, ST_FETCH},
        '{HOLD_NONE, 1'b0, 1'b0, 1'b1, 1'b0, COND_NEXT, ST_FETCH},
        '{HOLD_OUT,  1'b0, 1'b0, 1'b0, 1'b1, COND_MORE, ST_EMIT}
    };

endpackage
`default_nettype wire

// ===== hdl/lr_ifs.sv =====
// Interfaces: endpoint channel and pixel channel.
`timescale 1ns / 1ps
`default_nettype none
interface lr_pts_if;
    import lr_pkg::*;
    logic   valid;
    logic   ready;
    t_field x_start;
    t_field y_start;
    t_field x_end;
    t_field y_end;
    modport source (output valid, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lr_pix_if;
    import lr_pkg::*;
    logic   valid;
    logic   ready;
    t_field pixel_x;
    t_field pixel_y;
    logic   last_pixel;
    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface
`default_nettype wire

// ===== hdl/line_rasterizer.sv =====
// Top level: microcoded Bresenham line rasterizer, all octants.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | dir | transaction carries
//  --------+-----+----------------------------------------------
//  i_pts   | in  | x_start, y_start, x_end, y_end (one line)
//  o_pix   | out | pixel_x, pixel_y, last_pixel (one pixel)
//
//  A line passes through the fetch, axis select and error init steps,
//  then yields one pixel per cycle while the sink applies no back pressure.
//  The pixel rate is set by the single emit step that loops on itself.
//  Reset (synchronous, active low) returns to the fetch step and empties
//  the output register. A stalled sink holds the emit step; the output
//  register frees as soon as its pixel is taken, so emit refills it in the same cycle.
//
module line_rasterizer
    import lr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lr_pts_if.sink    i_pts,
    lr_pix_if.source  o_pix
);

    // Sequencer state.
    t_step  r_step;
    t_step  n_step;
    t_uword uw;

    // Captured endpoints, masked to the coordinate width.
    t_coord r_x0, r_y0, r_x1, r_y1;

    // Walk datapath: major coordinate a, minor b, spans, error term.
    t_coord r_a, r_a1, r_b;
    t_coord r_da, r_db;
    logic   r_neg;
    logic   r_swap;
    logic signed [ERR_BITS-1:0] r_err;

    // Output register.
    logic   r_out_valid;
    t_coord r_px, r_py;
    logic   r_last;

    logic   out_free;
    logic   go;
    logic   jump;
    logic   last;

    // Axis selection terms.
    t_coord dx_abs, dy_abs;
    logic   x_major;
    t_coord m0, m1, n0, n1;
    logic   rev;
    t_coord a0, a1, b0, b1;

    logic signed [ERR_BITS-1:0] two_db;
    logic signed [ERR_BITS-1:0] two_da;
    logic signed [ERR_BITS-1:0] da_ext;

    assign uw       = UCODE[r_step];
    assign out_free = !r_out_valid || o_pix.ready;
    assign last     = (r_a == r_a1);

    // Hold the step until its stall condition clears.
    always_comb begin
        unique case (uw.hold_on)
            HOLD_NONE: go = 1'b1;
            HOLD_IN:   go = i_pts.valid;
            HOLD_OUT:  go = out_free;
            default:   go = 1'b0;
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            COND_NEXT:   jump = 1'b0;
            COND_ALWAYS: jump = 1'b1;
            COND_MORE:   jump = !last;
            default:     jump = 1'b0;
        endcase
    end

    // Advance or jump; the step counter wraps after the emit step.
    always_comb begin
        n_step = r_step;
        if (go) begin
            n_step = jump ? uw.target : r_step + 1'b1;
        end
    end

    // Take no transaction while reset is held.
    assign i_pts.ready = i_rst_n && (uw.hold_on == HOLD_IN);

    // Pick the major axis and order the endpoints by major coordinate.
    always_comb begin
        dx_abs  = (r_x1 >= r_x0) ? r_x1 - r_x0 : r_x0 - r_x1;
        dy_abs  = (r_y1 >= r_y0) ? r_y1 - r_y0 : r_y0 - r_y1;
        x_major = (dy_abs < dx_abs);
        m0      = x_major ? r_x0 : r_y0;
        m1      = x_major ? r_x1 : r_y1;
        n0      = x_major ? r_y0 : r_x0;
        n1      = x_major ? r_y1 : r_x1;
        rev     = (m0 > m1);
        a0      = rev ? m1 : m0;
        a1      = rev ? m0 : m1;
        b0      = rev ? n1 : n0;
        b1      = rev ? n0 : n1;
    end

    assign two_db = $signed({2'b00, r_db, 1'b0});
    assign two_da = $signed({2'b00, r_da, 1'b0});
    assign da_ext = $signed({3'b000, r_da});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_FETCH;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (go && uw.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath; payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (go && uw.load_pts) begin
            r_x0 <= i_pts.x_start[COORD_BITS-1:0];
            r_y0 <= i_pts.y_start[COORD_BITS-1:0];
            r_x1 <= i_pts.x_end[COORD_BITS-1:0];
            r_y1 <= i_pts.y_end[COORD_BITS-1:0];
        end
        if (go && uw.load_axes) begin
            r_a    <= a0;
            r_a1   <= a1;
            r_b    <= b0;
            r_da   <= a1 - a0;
            r_neg  <= (b1 < b0);
            r_db   <= (b1 < b0) ? b0 - b1 : b1 - b0;
            r_swap <= !x_major;
        end
        if (go && uw.init_err) begin
            r_err <= two_db - da_ext;
        end
        if (go && uw.emit) begin
            r_px   <= r_swap ? r_b : r_a;
            r_py   <= r_swap ? r_a : r_b;
            r_last <= last;
            r_a    <= r_a + 1'b1;
            if (r_err > 0) begin
                r_b   <= r_neg ? r_b - 1'b1 : r_b + 1'b1;
                r_err <= r_err - two_da + two_db;
            end else begin
                r_err <= r_err + two_db;
            end
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = t_field'(r_px);
    assign o_pix.pixel_y    = t_field'(r_py);
    assign o_pix.last_pixel = r_last;

endmodule
`default_nettype wire
